FILE: design/wpcd_pkg.sv
// ----------------------------------------------------------------------------
// Weather packet decoder package
// Shared packet record, sensor type codes, conversion constants and the
// byte-wide CRC and bit-reverse helpers.
// ----------------------------------------------------------------------------
package wpcd_pkg;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [3:0] TYPE_UV    = 4'd4;
    localparam logic [3:0] TYPE_SOLAR = 4'd6;
    localparam logic [3:0] TYPE_TEMP  = 4'd8;
    localparam logic [3:0] TYPE_HUMID = 4'd10;
    localparam logic [3:0] TYPE_RAIN  = 4'd14;

    localparam int X_W    = 19;
    localparam int M_W    = 22;
    localparam int PROD_W = X_W + M_W;
    localparam int VAL_W  = 20;

    // Reciprocal multipliers: floor(x / d) == (x * M) >> K over the operand range.
    localparam logic [M_W-1:0] M_UV    = 22'd167773;   // divide by 25
    localparam logic [M_W-1:0] M_SOLAR = 22'd2199024;  // divide by 15625
    localparam logic [M_W-1:0] M_TEMP  = 22'd932068;   // divide by 9
    localparam logic [M_W-1:0] M_HUMID = 22'd838861;   // divide by 5
    localparam logic [5:0]     K_UV    = 6'd22;
    localparam logic [5:0]     K_SOLAR = 6'd35;
    localparam logic [5:0]     K_TEMP  = 6'd23;
    localparam logic [5:0]     K_HUMID = 6'd22;

    localparam logic [20:0] M_WIND = 21'd1973791;      // divide by 17
    localparam int          K_WIND = 25;

    localparam logic [15:0] TEMP_OFFSET = 16'd5120;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic       crc_ok;
    } t_pkt;

    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] v);
        logic [15:0] c;
        c = crc ^ {v, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: design/wpcd_front.sv
// ----------------------------------------------------------------------------
// Weather packet decoder front end
// Bit-reverses incoming bytes, counts them, runs the CRC and hands one
// packet record to the queue when the last byte of a packet arrives.
// ----------------------------------------------------------------------------
module wpcd_front #(
    parameter int PACKET_BYTES = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_packet_start,
    input  logic            i_q_full,
    output logic            o_stall,
    output logic            o_push,
    output wpcd_pkg::t_pkt  o_pkt
);
    import wpcd_pkg::*;

    localparam int CW = $clog2(PACKET_BYTES + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(PACKET_BYTES - 1);
    localparam logic [CW-1:0] NUM_BYTES = CW'(PACKET_BYTES);

    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_crc, n_crc;
    logic [7:0]    r_bytes [8];

    logic [CW-1:0] w_idx;
    logic [7:0]    w_byte;
    logic          w_accept;
    logic          w_live;
    logic [7:0]    w_b7;

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign w_idx    = i_packet_start ? '0 : r_count;
    assign w_live   = w_idx < NUM_BYTES;
    assign w_byte   = flip8(i_rx_byte);

    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        if (w_accept) begin
            if (i_packet_start) begin
                n_count = '0;
            end
            if (w_live) begin
                n_count = w_idx + CW'(1);
                if (w_idx < CW'(6)) begin
                    n_crc = crc_byte((w_idx == '0) ? 16'h0000 : r_crc, w_byte);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= '0;
        end else begin
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_live && (w_idx < CW'(8))) begin
            r_bytes[w_idx[2:0]] <= w_byte;
        end
    end

    // With an eight-byte packet the final byte is the low CRC byte itself.
    assign w_b7 = (w_idx == CW'(7)) ? w_byte : r_bytes[7];

    assign o_push        = w_accept && (w_idx == LAST_IDX);
    assign o_pkt.b0      = r_bytes[0];
    assign o_pkt.b1      = r_bytes[1];
    assign o_pkt.b2      = r_bytes[2];
    assign o_pkt.b3      = r_bytes[3];
    assign o_pkt.b4      = r_bytes[4];
    assign o_pkt.crc_ok  = (r_crc == {r_bytes[6], w_b7}) && (r_crc != 16'h0000);

endmodule

FILE: design/wpcd_queue.sv
// ----------------------------------------------------------------------------
// Weather packet decoder queue
// Four-entry register queue that decouples the byte front end from the
// conversion pipeline.
// ----------------------------------------------------------------------------
module wpcd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wpcd_pkg::t_pkt  i_pkt,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output wpcd_pkg::t_pkt  o_pkt
);
    import wpcd_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_pkt          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;
    logic          w_do_push;
    logic          w_do_pop;

    assign o_full    = r_count == (AW+1)'(DEPTH);
    assign o_empty   = r_count == '0;
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_pkt     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

endmodule

FILE: design/wpcd_back.sv
// ----------------------------------------------------------------------------
// Weather packet decoder back end
// Three-stage conversion pipeline: operand selection, reciprocal multiply,
// then shift, sign and output register.
// ----------------------------------------------------------------------------
module wpcd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  wpcd_pkg::t_pkt        i_pkt,
    output logic                  o_pop,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [2:0]            o_station_id,
    output logic [3:0]            o_sensor_type,
    output logic                  o_battery_low,
    output logic [7:0]            o_wind_raw,
    output logic [16:0]           o_wind_direction_q8,
    output logic                  o_crc_ok,
    output logic                  o_sensor_active,
    output logic signed [19:0]    o_sensor_value_q8
);
    import wpcd_pkg::*;

    typedef struct packed {
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic             crc_ok;
        logic             active;
        logic             direct;
        logic [VAL_W-1:0] direct_val;
        logic             neg;
        logic [VAL_W-1:0] base;
        logic [5:0]       shift;
    } t_ctl;

    logic              w_en;
    logic              r_s1_valid, r_s2_valid, r_out_valid;
    t_ctl              r_s1_ctl, r_s2_ctl;
    t_ctl              n_ctl;
    logic [X_W-1:0]    r_s1_x, n_x;
    logic [M_W-1:0]    r_s1_m, n_m;
    logic [20:0]       r_s1_wx;
    logic [PROD_W-1:0] r_s2_prod;
    logic [41:0]       r_s2_wprod;

    logic [9:0]        w_v;
    logic [15:0]       w_t;
    logic signed [16:0] w_d;
    logic [16:0]       w_dmag;
    logic [11:0]       w_h;

    logic [VAL_W-1:0]  w_q;
    logic [VAL_W-1:0]  w_mag;
    logic [VAL_W-1:0]  w_val;

    // The whole pipeline moves together whenever the output slot is empty or not stalled.
    assign w_en  = !r_out_valid || !i_stall;
    assign o_pop = w_en && !i_q_empty;

    assign w_v    = {i_pkt.b3, i_pkt.b4[7:6]};
    assign w_t    = {i_pkt.b3, i_pkt.b4};
    assign w_d    = $signed({1'b0, w_t}) - $signed({1'b0, TEMP_OFFSET});
    assign w_dmag = w_d[16] ? 17'(-w_d) : 17'(w_d);
    assign w_h    = {i_pkt.b4[7:4], i_pkt.b3};

    always_comb begin
        n_ctl            = '0;
        n_ctl.b0         = i_pkt.b0;
        n_ctl.b1         = i_pkt.b1;
        n_ctl.crc_ok     = i_pkt.crc_ok;
        n_x              = '0;
        n_m              = '0;
        if (!i_pkt.crc_ok) begin
            n_ctl.direct     = 1'b1;
            n_ctl.direct_val = '0;
        end else begin
            case (i_pkt.b0[7:4])
                TYPE_UV: begin
                    n_ctl.active = i_pkt.b3 != 8'hFF;
                    n_x          = X_W'({w_v, 7'b0});
                    n_m          = M_UV;
                    n_ctl.shift  = K_UV;
                end
                TYPE_SOLAR: begin
                    // v * 1.757936 * 256 splits into 450 * v plus 494 * v / 15625.
                    n_ctl.active = i_pkt.b3 != 8'hFF;
                    n_x          = X_W'(w_v) * X_W'(494);
                    n_m          = M_SOLAR;
                    n_ctl.shift  = K_SOLAR;
                    n_ctl.base   = VAL_W'(w_v) * VAL_W'(450);
                end
                TYPE_TEMP: begin
                    n_ctl.active = 1'b1;
                    n_x          = X_W'({w_dmag, 3'b0});
                    n_m          = M_TEMP;
                    n_ctl.shift  = K_TEMP;
                    n_ctl.neg    = w_d[16];
                end
                TYPE_HUMID: begin
                    n_ctl.active = 1'b1;
                    n_x          = X_W'({w_h, 7'b0});
                    n_m          = M_HUMID;
                    n_ctl.shift  = K_HUMID;
                end
                TYPE_RAIN: begin
                    n_ctl.active     = 1'b1;
                    n_ctl.direct     = 1'b1;
                    n_ctl.direct_val = VAL_W'({i_pkt.b3, 8'h00});
                end
                default: begin
                    n_ctl.direct     = 1'b1;
                    n_ctl.direct_val = -VAL_W'(256);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid  <= !i_q_empty;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_ctl   <= n_ctl;
            r_s1_x     <= n_x;
            r_s1_m     <= n_m;
            r_s1_wx    <= {i_pkt.b2, 13'b0} - {2'b00, i_pkt.b2, 11'b0};
            r_s2_ctl   <= r_s1_ctl;
            r_s2_prod  <= PROD_W'(r_s1_x) * PROD_W'(r_s1_m);
            r_s2_wprod <= 42'(r_s1_wx) * 42'(M_WIND);
        end
    end

    assign w_q   = VAL_W'(r_s2_prod >> r_s2_ctl.shift);
    assign w_mag = r_s2_ctl.base + w_q;
    assign w_val = r_s2_ctl.direct ? r_s2_ctl.direct_val
                 : (r_s2_ctl.neg ? VAL_W'(-w_mag) : w_mag);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_station_id        <= r_s2_ctl.b0[2:0];
            o_sensor_type       <= r_s2_ctl.b0[7:4];
            o_battery_low       <= r_s2_ctl.b0[3];
            o_wind_raw          <= r_s2_ctl.b1;
            o_wind_direction_q8 <= 17'(r_s2_wprod >> K_WIND);
            o_crc_ok            <= r_s2_ctl.crc_ok;
            o_sensor_active     <= r_s2_ctl.active;
            o_sensor_value_q8   <= $signed(w_val);
        end
    end

    assign o_valid = r_out_valid;

endmodule

FILE: design/weather_packet_crc_decoder.sv
// ----------------------------------------------------------------------------
// Weather packet CRC decoder
// Accepts one raw byte per cycle; emits one decoded record per packet.
// The record is written into the queue when the last byte is accepted, then passes
// through the three conversion pipeline stages; an output stall can hold it there.
// Throughput: one byte per cycle; only a full queue stalls the input.
// Synchronous active-low reset clears the byte count, CRC, queue and valids.
// ----------------------------------------------------------------------------
module weather_packet_crc_decoder #(
    parameter int PACKET_BYTES = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_packet_start,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_station_id,
    output logic [3:0]         o_sensor_type,
    output logic               o_battery_low,
    output logic [7:0]         o_wind_raw,
    output logic [16:0]        o_wind_direction_q8,
    output logic               o_crc_ok,
    output logic               o_sensor_active,
    output logic signed [19:0] o_sensor_value_q8
);
    import wpcd_pkg::*;

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_pkt w_push_pkt;
    t_pkt w_head_pkt;

    wpcd_front #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_rx_byte      (i_rx_byte),
        .i_packet_start (i_packet_start),
        .i_q_full       (w_full),
        .o_stall        (o_stall),
        .o_push         (w_push),
        .o_pkt          (w_push_pkt)
    );

    wpcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pkt   (w_push_pkt),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_pkt   (w_head_pkt)
    );

    wpcd_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_empty           (w_empty),
        .i_pkt               (w_head_pkt),
        .o_pop               (w_pop),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_station_id        (o_station_id),
        .o_sensor_type       (o_sensor_type),
        .o_battery_low       (o_battery_low),
        .o_wind_raw          (o_wind_raw),
        .o_wind_direction_q8 (o_wind_direction_q8),
        .o_crc_ok            (o_crc_ok),
        .o_sensor_active     (o_sensor_active),
        .o_sensor_value_q8   (o_sensor_value_q8)
    );

    // A packet record is never offered to a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("packet record pushed into a full queue");

    // The back end never pops an empty queue.
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_empty) |-> 1'b0)
        else $error("pop from an empty queue");

    // A failed CRC yields an inactive reading of zero.
    a_bad_crc_clears_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_crc_ok) |-> (!o_sensor_active && o_sensor_value_q8 == 20'sd0))
        else $error("bad CRC record carries a reading");

    // An active reading always comes with a good CRC.
    a_active_needs_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sensor_active) |-> o_crc_ok)
        else $error("active reading without a good CRC");

endmodule
